// File: hdl/psch_pkg.sv
// Package for the priority scheduler: sizing constants, request/result
// structs and the sequencer state type. No dependencies.
package psch_pkg;

  localparam int MAX_PROCS     = 16;
  localparam int BURST_BITS    = 16;
  localparam int PRIORITY_BITS = 8;

  localparam int IDX_W  = $clog2(MAX_PROCS);
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int ELAP_W = BURST_BITS + $clog2(MAX_PROCS) + 1;
  localparam int MEM_W  = BURST_BITS + PRIORITY_BITS;

  // Fixed field widths of the result.
  localparam int ID_W    = 4;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 20;
  localparam int TOT_W   = 24;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic [15:0] burst_time;
    logic [7:0]  priority_req;
    logic        last_job;
  } job_req_t;

  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] job_burst;
    logic [TIME_W-1:0]  waiting_time;
    logic [TIME_W-1:0]  turnaround_time;
    logic [TOT_W-1:0]   total_waiting;
    logic [TOT_W-1:0]   total_turnaround;
    logic [COUNT_W-1:0] job_count;
    logic               overflow;
    logic               last_result;
  } job_res_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } sched_state_t;

endpackage

// File: hdl/priority_schedule_times.sv
// Non-preemptive priority scheduler: loads jobs, then emits them by priority.
// After the last job, each result takes a full read pass of the job RAM,
//   a compare per word read, and an emit that waits while the output stalls.
// Throughput: one job per cycle while loading; jobs stall in scan and emit.
// Reset (rst, synchronous): empty job set, no overflow, output register empty.
// Depends on psch_pkg and psch_ram.
module priority_schedule_times (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_stall,
  input  psch_pkg::job_req_t job,
  output logic              res_valid,
  input  logic              res_stall,
  output psch_pkg::job_res_t res
);

  localparam int IDX_W  = psch_pkg::IDX_W;
  localparam int CNT_W  = psch_pkg::CNT_W;
  localparam int ELAP_W = psch_pkg::ELAP_W;
  localparam int BB     = psch_pkg::BURST_BITS;
  localparam int PB     = psch_pkg::PRIORITY_BITS;
  localparam int NP     = psch_pkg::MAX_PROCS;

  psch_pkg::sched_state_t state, state_next;

  // Load side: count of stored jobs and the overflow mark.
  logic [CNT_W-1:0] cnt;
  logic             ovf;
  logic             job_fire;
  logic             store_ok;

  // Scan side: read issue counter, registered read valid and index, best candidate.
  logic [CNT_W-1:0] scan_cnt;
  logic             rd_en;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [psch_pkg::MEM_W-1:0] rd_data;
  logic [BB-1:0]    rd_burst;
  logic [PB-1:0]    rd_prio;
  logic             scan_last;
  logic             take;

  logic             best_vld;
  logic [IDX_W-1:0] best_idx;
  logic [BB-1:0]    best_burst;
  logic [PB-1:0]    best_prio;

  // Jobs already emitted in this schedule.
  logic [NP-1:0]    served;

  // Emit side: rank, running time and sums.
  logic [CNT_W-1:0]           rank;
  logic [ELAP_W-1:0]          elapsed;
  logic [psch_pkg::TOT_W-1:0] wsum;
  logic [psch_pkg::TOT_W-1:0] tsum;
  logic [ELAP_W-1:0]          tat;
  logic [psch_pkg::TOT_W-1:0] wsum_next;
  logic [psch_pkg::TOT_W-1:0] tsum_next;
  logic                       rank_last;
  logic                       out_free;
  logic                       emit_fire;
  psch_pkg::job_res_t         res_next;

  assign job_fire = job_valid && !job_stall;
  assign store_ok = cnt < CNT_W'(NP);

  // Jobs live in one RAM as {burst, priority}; the id is the address itself.
  psch_ram #(
    .WIDTH (psch_pkg::MEM_W),
    .DEPTH (NP)
  ) u_job_ram (
    .clk     (clk),
    .wr_en   (job_fire && store_ok),
    .wr_addr (cnt[IDX_W-1:0]),
    .wr_data ({BB'(job.burst_time), PB'(job.priority_req)}),
    .rd_en   (rd_en),
    .rd_addr (scan_cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_burst  = rd_data[psch_pkg::MEM_W-1:PB];
  assign rd_prio   = rd_data[PB-1:0];
  assign scan_last = rd_vld && (CNT_W'(rd_idx) == cnt - 1'b1);

  // Strict compare over ascending addresses keeps ties in load order.
  assign take = rd_vld && !served[rd_idx] && (!best_vld || rd_prio < best_prio);

  assign out_free  = !res_valid || !res_stall;
  assign emit_fire = (state == psch_pkg::ST_EMIT) && out_free;
  assign rank_last = rank == cnt - 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      psch_pkg::ST_LOAD: begin
        if (job_fire && job.last_job) begin
          state_next = psch_pkg::ST_SCAN;
        end
      end
      psch_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = psch_pkg::ST_EMIT;
        end
      end
      psch_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = rank_last ? psch_pkg::ST_LOAD : psch_pkg::ST_SCAN;
        end
      end
      default: state_next = psch_pkg::ST_LOAD;
    endcase
  end

  // Handshake and read issue per state.
  always_comb begin
    job_stall = 1'b1;
    rd_en     = 1'b0;
    unique case (state)
      psch_pkg::ST_LOAD: job_stall = 1'b0;
      psch_pkg::ST_SCAN: rd_en = scan_cnt < cnt;
      psch_pkg::ST_EMIT: rd_en = 1'b0;
      default: job_stall = 1'b1;
    endcase
  end

  // Result of the current best job.
  always_comb begin
    tat       = elapsed + ELAP_W'(best_burst);
    wsum_next = wsum + psch_pkg::TOT_W'(elapsed);
    tsum_next = tsum + psch_pkg::TOT_W'(tat);
    res_next.job_id           = psch_pkg::ID_W'(best_idx);
    res_next.job_burst        = psch_pkg::BURST_W'(best_burst);
    res_next.waiting_time     = psch_pkg::TIME_W'(elapsed);
    res_next.turnaround_time  = psch_pkg::TIME_W'(tat);
    res_next.total_waiting    = rank_last ? wsum_next : '0;
    res_next.total_turnaround = rank_last ? tsum_next : '0;
    res_next.job_count        = psch_pkg::COUNT_W'(cnt);
    res_next.overflow         = ovf;
    res_next.last_result      = rank_last;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= psch_pkg::ST_LOAD;
      cnt       <= '0;
      ovf       <= 1'b0;
      scan_cnt  <= '0;
      rd_vld    <= 1'b0;
      best_vld  <= 1'b0;
      served    <= '0;
      rank      <= '0;
      elapsed   <= '0;
      wsum      <= '0;
      tsum      <= '0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;

      // Load: store the job or mark it dropped.
      if (job_fire) begin
        if (store_ok) begin
          cnt <= cnt + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end

      // Scan: advance the read address, track the best candidate.
      if (rd_en) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (take) begin
        best_vld <= 1'b1;
      end

      // Emit: retire the best job and restart the scan, or finish the set.
      if (emit_fire) begin
        scan_cnt <= '0;
        best_vld <= 1'b0;
        if (rank_last) begin
          cnt     <= '0;
          ovf     <= 1'b0;
          served  <= '0;
          rank    <= '0;
          elapsed <= '0;
          wsum    <= '0;
          tsum    <= '0;
        end else begin
          served[best_idx] <= 1'b1;
          rank    <= rank + 1'b1;
          elapsed <= tat;
          wsum    <= wsum_next;
          tsum    <= tsum_next;
        end
      end

      // Output register: hold while stalled, drop once taken.
      if (emit_fire) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= scan_cnt[IDX_W-1:0];
    end
    if (take) begin
      best_idx   <= rd_idx;
      best_burst <= rd_burst;
      best_prio  <= rd_prio;
    end
    if (emit_fire) begin
      res <= res_next;
    end
  end

endmodule

// File: hdl/psch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module psch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/psch_chk.sv
// Port-level checker for the priority scheduler, bound to the top level.
// Depends on psch_pkg.
module psch_chk (
  input logic               clk,
  input logic               rst,
  input logic               job_valid,
  input logic               job_stall,
  input psch_pkg::job_req_t job,
  input logic               res_valid,
  input logic               res_stall,
  input psch_pkg::job_res_t res
);

  // A stalled result holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // The final job of a set closes the load side.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_stall && job.last_job |=> job_stall)
    else $error("request taken right after last job");

  // Turnaround is waiting time plus own burst, within the field width.
  a_tat: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.turnaround_time ==
      psch_pkg::TIME_W'(res.waiting_time + psch_pkg::TIME_W'(res.job_burst)))
    else $error("turnaround mismatch");

  // Totals only on the final result, and a set is never empty.
  a_totals: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.job_count != '0 &&
      (res.last_result || (res.total_waiting == '0 && res.total_turnaround == '0)))
    else $error("bad totals or job count");

endmodule

bind priority_schedule_times psch_chk u_psch_chk (.*);

// File: dv/tb_priority_schedule_times.sv
// Self-checking bench for priority_schedule_times: directed job sets from a table,
// then random sets, every result checked against a priority-order predictor.
// Depends on psch_pkg and the priority_schedule_times RTL.
module tb_priority_schedule_times;
  import psch_pkg::*;

  // Longest schedule pass: n results, each a full RAM scan plus compare and emit.
  localparam int unsigned SET_CYCLES   = MAX_PROCS * (MAX_PROCS + 2) + 16;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_JOBS  = 450;
  localparam int unsigned HOLD_CYCLES  = 700;

  typedef struct {
    job_req_t req;
    bit       typed;    // want holds a hand-written result for this row
    job_res_t want;
  } dir_row_t;

  logic     clk;
  logic     rst;
  logic     job_valid;
  logic     job_stall;
  job_req_t job;
  logic     res_valid;
  logic     res_stall;
  job_res_t res;

  // Bench-side control, written with nonblocking assignments by the driver.
  bit quiet;      // no idling on either side while set
  bit hold_go;    // ask the receiver for its one long hold-off

  int unsigned cycles;
  int unsigned mismatches;

  // Predictor copy of the job store and the results it has scheduled.
  logic [BURST_W-1:0]       held_burst [MAX_PROCS];
  logic [PRIORITY_BITS-1:0] held_prio  [MAX_PROCS];
  int unsigned              held_n;
  bit                       held_ovf;
  job_res_t                 due_results [$];

  priority_schedule_times dut (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("ERROR cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic cmp_field(input string what, input longint unsigned got,
                           input longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Store one request; on the last one, serve the stored jobs by ascending
  // priority (ties in load order) and queue one result per job.
  function automatic void book_job(input job_req_t r);
    int unsigned         order [MAX_PROCS];
    int unsigned         j;
    int unsigned         p;
    logic [ELAP_W-1:0]   elapsed;
    logic [ELAP_W-1:0]   wt;
    logic [ELAP_W-1:0]   tat;
    logic [TOT_W:0]      wsum;
    logic [TOT_W:0]      tsum;
    bit                  fin;
    job_res_t            o;
    if (held_n < MAX_PROCS) begin
      held_burst[held_n] = r.burst_time;
      held_prio[held_n]  = r.priority_req;
      held_n++;
    end else begin
      held_ovf = 1'b1;
    end
    if (!r.last_job) return;

    // Stable insertion sort of load positions by priority.
    for (int i = 0; i < held_n; i++) begin
      j = i;
      while (j > 0 && held_prio[order[j-1]] > held_prio[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end

    elapsed = '0;
    wsum    = '0;
    tsum    = '0;
    for (int i = 0; i < held_n; i++) begin
      p       = order[i];
      wt      = elapsed;
      tat     = wt + ELAP_W'(held_burst[p]);
      elapsed = tat;
      wsum    = wsum + (TOT_W+1)'(wt);
      tsum    = tsum + (TOT_W+1)'(tat);
      fin     = (i == held_n - 1);
      o.job_id           = ID_W'(p);
      o.job_burst        = held_burst[p];
      o.waiting_time     = TIME_W'(wt);
      o.turnaround_time  = TIME_W'(tat);
      o.total_waiting    = fin ? TOT_W'(wsum) : '0;
      o.total_turnaround = fin ? TOT_W'(tsum) : '0;
      o.job_count        = COUNT_W'(held_n);
      o.overflow         = held_ovf;
      o.last_result      = fin;
      due_results.push_back(o);
    end
    held_n   = 0;
    held_ovf = 1'b0;
  endfunction

  // Offer one request and hold it until accepted, then predict. A typed row
  // replaces the predicted result of its one-job set with the hand-written one.
  task automatic send_job(input job_req_t r, input bit typed, input job_res_t want);
    while (!quiet && $urandom_range(99) < 8) begin
      job_valid <= 1'b0;
      @(posedge clk);
    end
    job_valid <= 1'b1;
    job       <= r;
    @(posedge clk);
    while (job_stall) @(posedge clk);
    book_job(r);
    if (typed) due_results[due_results.size() - 1] = want;
  endtask

  // Drop valid and wait for every scheduled result to come back.
  task automatic drain_results();
    job_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // One random job set. Mostly short sets, some full ones, a few that run
  // past capacity so that the overflow flag and a dropped last job show up.
  task automatic send_random_set(inout int unsigned sent);
    int unsigned pick;
    int unsigned n;
    int unsigned prio_max;
    bit          wide_burst;
    job_req_t    r;
    pick = $urandom_range(99);
    if (pick < 70)      n = $urandom_range(6, 1);
    else if (pick < 92) n = $urandom_range(16, 7);
    else                n = $urandom_range(20, 17);
    // Narrow priorities give plenty of ties.
    prio_max   = $urandom_range(1) ? 255 : 3;
    wide_burst = 1'($urandom_range(1));
    for (int k = 0; k < n; k++) begin
      r.burst_time = wide_burst ? 16'($urandom) : 16'($urandom_range(300));
      if ($urandom_range(19) == 0) r.burst_time = $urandom_range(1) ? '1 : '0;
      r.priority_req = 8'($urandom_range(prio_max));
      r.last_job     = (k == n - 1);
      send_job(r, 1'b0, '0);
      sent++;
    end
  endtask

  // Receiver: random stalls, a calm stretch, and one long hold-off that lets
  // the block fill and push back on the request side.
  initial begin
    bit held;
    held = 1'b0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_stall <= quiet ? 1'b0 : ($urandom_range(99) < 8);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    job_res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing expected, job_id", res.job_id, 0);
      end else begin
        want = due_results.pop_front();
        cmp_field("job_id",           res.job_id,           want.job_id);
        cmp_field("job_burst",        res.job_burst,        want.job_burst);
        cmp_field("waiting_time",     res.waiting_time,     want.waiting_time);
        cmp_field("turnaround_time",  res.turnaround_time,  want.turnaround_time);
        cmp_field("total_waiting",    res.total_waiting,    want.total_waiting);
        cmp_field("total_turnaround", res.total_turnaround, want.total_turnaround);
        cmp_field("job_count",        res.job_count,        want.job_count);
        cmp_field("overflow",         res.overflow,         want.overflow);
        cmp_field("last_result",      res.last_result,      want.last_result);
      end
    end
  end

  initial begin
    dir_row_t    dir_rows [$];
    int unsigned sent;
    bit          paused;
    rst       <= 1'b1;
    job_valid <= 1'b0;
    job       <= '0;
    quiet     <= 1'b0;
    hold_go   <= 1'b0;
    held_n    = 0;
    held_ovf  = 1'b0;
    sent      = 0;
    paused    = 1'b0;

    // Directed table. One-job sets at the extremes have their result typed in.
    dir_rows.push_back(dir_row_t'{job_req_t'{16'hFFFF, 8'hFF, 1'b1}, 1'b1,
      job_res_t'{4'd0, 16'hFFFF, 20'd0, 20'h0FFFF, 24'd0, 24'h00FFFF, 5'd1, 1'b0, 1'b1}});
    dir_rows.push_back(dir_row_t'{job_req_t'{16'h0000, 8'h00, 1'b1}, 1'b1,
      job_res_t'{4'd0, 16'd0, 20'd0, 20'd0, 24'd0, 24'd0, 5'd1, 1'b0, 1'b1}});
    // Ties on priority: equal values must come out in load order.
    dir_rows.push_back(dir_row_t'{job_req_t'{16'd5, 8'd3, 1'b0}, 1'b0, '0});
    dir_rows.push_back(dir_row_t'{job_req_t'{16'd7, 8'd1, 1'b0}, 1'b0, '0});
    dir_rows.push_back(dir_row_t'{job_req_t'{16'd2, 8'd3, 1'b0}, 1'b0, '0});
    dir_rows.push_back(dir_row_t'{job_req_t'{16'd9, 8'd1, 1'b1}, 1'b0, '0});
    // Fill the store, then a last job that finds it full and is dropped.
    for (int k = 0; k < MAX_PROCS; k++)
      dir_rows.push_back(dir_row_t'{job_req_t'{(k % 3 == 0) ? 16'hFFFF : 16'(k * 100),
                                               8'(k * 37), 1'b0}, 1'b0, '0});
    dir_rows.push_back(dir_row_t'{job_req_t'{16'd1, 8'd0, 1'b1}, 1'b0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_job(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    // Random sets; a calm stretch, then the long receiver hold-off while
    // requests keep coming, then one pause until every result is back.
    while (sent < RANDOM_JOBS) begin
      quiet <= (sent >= 120 && sent < 230);
      if (sent >= 260) hold_go <= 1'b1;
      if (!paused && sent >= 360) begin
        drain_results();
        paused = 1'b1;
      end
      send_random_set(sent);
    end

    drain_results();
    repeat (SET_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/psch_pkg.sv
hdl/psch_ram.sv
hdl/priority_schedule_times.sv
hdl/psch_chk.sv
dv/tb_priority_schedule_times.sv
